### design/sbbp_pkg.sv
`timescale 1ns / 1ps

package sbbp_pkg;

   // Default build values
   localparam int FFT_POINTS_DEF = 64;
   localparam int COLUMNS_DEF    = 16;
   localparam int NBANDS         = 16;

   // Field widths
   localparam int IDX_W      = 5;
   localparam int MAG_W      = 16;
   localparam int SUM_W      = 21;
   localparam int COL_OUT_W  = 4;
   localparam int BAR_W      = 5;
   localparam int ROW_W      = 4;
   localparam int PEAK_W     = 6;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int STEP_W     = 2;
   localparam int QUO_W      = 4;

   // Register reset values
   localparam logic [MAG_W-1:0] NOISE_RESET   = 16'd100;
   localparam logic [MAG_W-1:0] DIVISOR_RESET = 16'd50;

   // Peak tracking constants
   localparam logic signed [PEAK_W-1:0] PEAK_EMPTY      = -6'sd1;
   localparam logic signed [PEAK_W-1:0] PEAK_COL1_RESET = 6'sd15;
   localparam logic [ROW_W-1:0]         MAX_ROW         = 4'd15;
   localparam logic [BAR_W-1:0]         MAX_BAR         = 5'd16;

   // Upper bin of each band; the last band runs up to FFT_POINTS/2 - 1
   localparam logic [IDX_W-1:0] BREAKS [NBANDS-1] = '{
      5'd2, 5'd3, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
      5'd16, 5'd17, 5'd19, 5'd21, 5'd23, 5'd26, 5'd28
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_THRESHOLD = 2'd0,
      CSR_BAR_DIVISOR     = 2'd1,
      CSR_PEAK_ENABLE     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SAT,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accumulate;
      logic load;
      logic sat_check;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic step_last;
      logic col_last;
      logic out_free;
   } dp_status_type;

   // First band whose breakpoint is at or above the bin
   function automatic logic [3:0] band_lookup(input logic [IDX_W-1:0] idx);
      logic [3:0] band;
      band = 4'(NBANDS - 1);
      for (int b = NBANDS - 2; b >= 0; b--) begin
         if (idx <= BREAKS[b]) begin
            band = 4'(b);
         end
      end
      return band;
   endfunction

endpackage

### design/sbbp_req_if.sv
`timescale 1ns / 1ps

interface sbbp_req_if import sbbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] bin_index;
   logic [MAG_W-1:0] magnitude;
   logic             frame_end;

   modport source (output valid, output bin_index, output magnitude, output frame_end,
                   input ready);
   modport sink   (input valid, input bin_index, input magnitude, input frame_end,
                   output ready);
endinterface

### design/sbbp_rsp_if.sv
`timescale 1ns / 1ps

interface sbbp_rsp_if import sbbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COL_OUT_W-1:0] column;
   logic [BAR_W-1:0]     bar_height;
   logic [ROW_W-1:0]     peak_row;
   logic                 peak_visible;
   logic                 last_column;

   modport source (output valid, output column, output bar_height, output peak_row,
                   output peak_visible, output last_column, input ready);
   modport sink   (input valid, input column, input bar_height, input peak_row,
                   input peak_visible, input last_column, output ready);
endinterface

### design/sbbp_ctrl.sv
`timescale 1ns / 1ps

module sbbp_ctrl import sbbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_frame_end,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accumulate = 1'b1;
               if (req_frame_end) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat_check = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.col_last ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/sbbp_datapath.sv
`timescale 1ns / 1ps

module sbbp_datapath import sbbp_pkg::*; #(
   parameter int FFT_POINTS = FFT_POINTS_DEF,
   parameter int COLUMNS    = COLUMNS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [IDX_W-1:0]      req_bin_index,
   input  logic [MAG_W-1:0]      req_magnitude,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [COL_OUT_W-1:0]  rsp_column,
   output logic [BAR_W-1:0]      rsp_bar_height,
   output logic [ROW_W-1:0]      rsp_peak_row,
   output logic                  rsp_peak_visible,
   output logic                  rsp_last_column
);

   localparam int HALF  = FFT_POINTS / 2;
   localparam int NCOL  = (COLUMNS < NBANDS) ? COLUMNS : NBANDS;
   localparam int COL_W = $clog2(NCOL);

   // Config registers
   logic [MAG_W-1:0] noise_threshold_ff;
   logic [MAG_W-1:0] bar_divisor_ff;
   logic             peak_enable_ff;

   // Band and peak storage
   logic [SUM_W-1:0]         sums_ff [NCOL];
   logic signed [PEAK_W-1:0] peaks_ff [NCOL];

   // Divider and column walk
   logic [COL_W-1:0]  col_ff;
   logic [SUM_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  dsh_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic              sat_ff;
   logic [STEP_W-1:0] step_ff;

   // Output register
   logic                 rsp_valid_ff;
   logic [COL_OUT_W-1:0] rsp_column_ff;
   logic [BAR_W-1:0]     rsp_bar_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic                 rsp_vis_ff;
   logic                 rsp_last_ff;

   logic [3:0]               band;
   logic [COL_W-1:0]         band_idx;
   logic                     acc_hit;
   logic [SUM_W:0]           sum_add;
   logic [SUM_W-1:0]         sum_sat;
   logic [MAG_W-1:0]         div_eff;
   logic                     rem_ge;
   logic [BAR_W-1:0]         bar;
   logic signed [PEAK_W-1:0] peak_cur;
   logic signed [PEAK_W-1:0] peak_new;
   logic signed [PEAK_W-1:0] bar_s;
   logic [ROW_W-1:0]         row;
   logic                     vis;
   logic                     col_last;
   logic                     out_free;

   // Accumulate path: band decode, read, saturating add
   always_comb begin
      band     = band_lookup(req_bin_index);
      band_idx = band[COL_W-1:0];
      acc_hit  = (req_bin_index >= IDX_W'(2)) && (32'(req_bin_index) < HALF)
                 && (req_magnitude > noise_threshold_ff) && (32'(band) < NCOL);
      sum_add  = {1'b0, sums_ff[band_idx]} + (SUM_W+1)'(req_magnitude);
      sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
   end

   // Divide path
   assign div_eff = (bar_divisor_ff == '0) ? MAG_W'(1) : bar_divisor_ff;
   assign rem_ge  = (rem_ff >= dsh_ff);
   assign bar     = sat_ff ? MAX_BAR : {1'b0, quo_ff};

   // Falling peak
   always_comb begin
      peak_cur = peaks_ff[col_ff];
      bar_s    = $signed({1'b0, bar});
      if (bar_s > peak_cur) begin
         peak_new = bar_s;
      end else if (peak_cur > PEAK_EMPTY) begin
         peak_new = peak_cur - PEAK_W'(1);
      end else begin
         peak_new = peak_cur;
      end
      vis = 1'b0;
      row = '0;
      if (peak_enable_ff && (peak_new > 0)) begin
         vis = 1'b1;
         row = (peak_new > $signed({2'b00, MAX_ROW})) ? MAX_ROW : peak_new[ROW_W-1:0];
      end
   end

   assign col_last = (col_ff == COL_W'(NCOL - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.step_last = (step_ff == '0);
   assign status.col_last  = col_last;
   assign status.out_free  = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_threshold_ff <= NOISE_RESET;
         bar_divisor_ff     <= DIVISOR_RESET;
         peak_enable_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NOISE_THRESHOLD: noise_threshold_ff <= csr_write_data;
            CSR_BAR_DIVISOR:     bar_divisor_ff     <= csr_write_data;
            CSR_PEAK_ENABLE:     peak_enable_ff     <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCOL; i++) begin
            sums_ff[i]  <= '0;
            peaks_ff[i] <= (i == 1) ? PEAK_COL1_RESET : PEAK_EMPTY;
         end
      end else begin
         if (cmd.accumulate && acc_hit) begin
            sums_ff[band_idx] <= sum_sat;
         end
         if (cmd.load) begin
            sums_ff[col_ff] <= '0;
         end
         if (cmd.emit && peak_enable_ff) begin
            peaks_ff[col_ff] <= peak_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (cmd.emit) begin
         col_ff <= col_last ? '0 : col_ff + COL_W'(1);
      end
   end

   // Saturating restoring divide: range check, then four quotient bits
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= sums_ff[col_ff];
         quo_ff <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.sat_check) begin
         dsh_ff  <= {2'b00, div_eff, 3'b000};
         step_ff <= '1;
         if (rem_ff >= {1'b0, div_eff, 4'b0000}) begin
            sat_ff <= 1'b1;
            rem_ff <= '0;
         end
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         quo_ff  <= {quo_ff[QUO_W-2:0], rem_ge};
         dsh_ff  <= dsh_ff >> 1;
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_column_ff <= COL_OUT_W'(col_ff);
         rsp_bar_ff    <= bar;
         rsp_row_ff    <= row;
         rsp_vis_ff    <= vis;
         rsp_last_ff   <= col_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column       = rsp_column_ff;
   assign rsp_bar_height   = rsp_bar_ff;
   assign rsp_peak_row     = rsp_row_ff;
   assign rsp_peak_visible = rsp_vis_ff;
   assign rsp_last_column  = rsp_last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("emit while output register is held");

   a_sum_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (sums_ff[$past(col_ff)] == '0))
      else $error("band sum not cleared after load");

   a_bar_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bar_ff <= MAX_BAR))
      else $error("bar height above saturation");

   a_last_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_column_ff == COL_OUT_W'(NCOL - 1)))
      else $error("last column flag on wrong column");

endmodule

### design/spectrum_band_bars_peak_hold.sv
`timescale 1ns / 1ps

// Spectrum band bars with falling peak hold. Requests carry one FFT magnitude
// bin each; bins 2 .. FFT_POINTS/2-1 above the noise threshold add into one of
// up to 16 bands (saturating at 2^21-1). Ordinary bins are taken one per clock
// while no frame is being processed. A request with frame_end set is
// accumulated and then holds req_bus.ready low while each of the
// min(COLUMNS,16) columns is processed in turn (load, range check, four
// restoring divide steps, emit), and it stays low longer while rsp_bus.ready
// is held low. All columns share one divider that works out one quotient bit
// per cycle. Each column yields one response: bar height = sum / bar_divisor
// (0 acts as 1), saturated at 16, plus an optional falling peak row; the band
// sum clears as the column is read. Config is to be written through the csr_
// port while no frame is being emitted; the block itself does not enforce this.

module spectrum_band_bars_peak_hold import sbbp_pkg::*; #(
   parameter int FFT_POINTS = FFT_POINTS_DEF,
   parameter int COLUMNS    = COLUMNS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sbbp_req_if.sink              req_bus,
   sbbp_rsp_if.source            rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer: accepts bins, walks the columns on frame end
   sbbp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_frame_end (req_bus.frame_end),
      .req_ready     (req_bus.ready),
      .status        (status),
      .cmd           (cmd)
   );

   // Band sums, divider, peaks, response register
   sbbp_datapath #(
      .FFT_POINTS (FFT_POINTS),
      .COLUMNS    (COLUMNS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bin_index    (req_bus.bin_index),
      .req_magnitude    (req_bus.magnitude),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_column       (rsp_bus.column),
      .rsp_bar_height   (rsp_bus.bar_height),
      .rsp_peak_row     (rsp_bus.peak_row),
      .rsp_peak_visible (rsp_bus.peak_visible),
      .rsp_last_column  (rsp_bus.last_column)
   );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

// Band bars with falling peak hold: directed frames, then random frames.
// Requests go out in bursts. Responses are checked in order against an
// in-bench model of the band sums and the peaks.
module tb;
   import sbbp_pkg::*;

   localparam int HALF_POINTS = FFT_POINTS_DEF / 2;
   localparam int NCOL        = (COLUMNS_DEF < NBANDS) ? COLUMNS_DEF : NBANDS;
   localparam int SUM_MAX     = (1 << SUM_W) - 1;
   localparam int PEAK_TOP    = 15;
   localparam int BAR_TOP     = 16;
   localparam int RANDOM_REQS = 370;

   // Upper bin of each band, last band closes at half the FFT size
   localparam int BAND_TOP [NBANDS] = '{
      2, 3, 4, 6, 8, 10, 12, 14, 16, 17, 19, 21, 23, 26, 28, HALF_POINTS
   };

   typedef struct {
      logic [COL_OUT_W-1:0] column;
      logic [BAR_W-1:0]     bar;
      logic [ROW_W-1:0]     row;
      logic                 visible;
      logic                 last;
   } column_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   sbbp_req_if req_bus ();
   sbbp_rsp_if rsp_bus ();

   spectrum_band_bars_peak_hold u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------
   // Model state: register copies, band sums, peaks
   // ---------------------------------------------------------------
   int unsigned       noise_floor;
   int unsigned       bar_div;
   logic              peaks_on;
   int unsigned       band_total [NBANDS];
   int                peak_level [NBANDS];
   column_result_type expected_columns [$];

   int errors;
   int requests_sent;
   int frames_sent;
   int columns_checked;
   int reg_writes;
   int random_requests;

   // Sender burst bookkeeping
   int burst_left;
   bit req_up;

   // ---------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #10_000_000;
      $display("Timeout: %0d column results still pending", expected_columns.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------
   // Model: fold one accepted request in, queue the columns it yields
   // ---------------------------------------------------------------
   function automatic void record_request(input logic [IDX_W-1:0] idx,
                                          input logic [MAG_W-1:0] mag,
                                          input logic fend);
      int                band;
      int unsigned       total;
      int unsigned       divisor;
      int                bar;
      column_result_type r;
      // bins 0, 1 and anything past half the FFT never land in a band
      if (idx >= 2 && idx < HALF_POINTS && mag > noise_floor) begin
         band = 0;
         while (idx > BAND_TOP[band]) band++;
         if (band < NCOL) begin
            total = band_total[band] + mag;
            band_total[band] = (total > SUM_MAX) ? SUM_MAX : total;
         end
      end
      if (!fend) return;
      frames_sent++;
      divisor = (bar_div == 0) ? 1 : bar_div;   // zero divisor acts as one
      for (int c = 0; c < NCOL; c++) begin
         bar = int'(band_total[c] / divisor);
         if (bar > BAR_TOP) bar = BAR_TOP;
         r.column  = COL_OUT_W'(c);
         r.bar     = BAR_W'(bar);
         r.row     = '0;
         r.visible = 1'b0;
         r.last    = (c == NCOL - 1);
         // falling peak: jump to bar, otherwise drop a row down to -1
         if (peaks_on) begin
            if (bar > peak_level[c]) peak_level[c] = bar;
            else if (peak_level[c] > -1) peak_level[c]--;
            if (peak_level[c] > 0) begin
               r.visible = 1'b1;
               r.row = ROW_W'((peak_level[c] > PEAK_TOP) ? PEAK_TOP : peak_level[c]);
            end
         end
         expected_columns.push_back(r);
         band_total[c] = 0;
      end
   endfunction

   // ---------------------------------------------------------------
   // Request sender: bursts of random length, random gaps between
   // ---------------------------------------------------------------
   task automatic send_bin(input logic [IDX_W-1:0] idx, input logic [MAG_W-1:0] mag,
                           input logic fend);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
         if (req_up) begin
            req_bus.valid <= 1'b0;
            req_up = 0;
         end
         repeat (gap) @(posedge clock);
         // long bursts give stretches with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 8);
      end
      req_bus.valid     <= 1'b1;
      req_bus.bin_index <= idx;
      req_bus.magnitude <= mag;
      req_bus.frame_end <= fend;
      req_up = 1;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      requests_sent++;
      record_request(idx, mag, fend);
   endtask

   // Stop sending and wait until every column has come back and the block settles
   task automatic wait_for_columns();
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 0;
      end
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // Write all three registers on back-to-back cycles; block must be idle
   task automatic configure(input logic [15:0] noise, input logic [15:0] divisor,
                            input logic [15:0] peak_word);
      wait_for_columns();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_NOISE_THRESHOLD;
      csr_write_data   <= noise;
      @(posedge clock);
      noise_floor = noise;
      csr_index      <= CSR_BAR_DIVISOR;
      csr_write_data <= divisor;
      @(posedge clock);
      bar_div = divisor;
      csr_index      <= CSR_PEAK_ENABLE;
      csr_write_data <= peak_word;
      @(posedge clock);
      peaks_on = peak_word[0];
      csr_write_enable <= 1'b0;
      reg_writes += 3;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      column_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         columns_checked++;
         if (expected_columns.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected column result: col %0d bar %0d row %0d vis %0d last %0d",
                        rsp_bus.column, rsp_bus.bar_height, rsp_bus.peak_row,
                        rsp_bus.peak_visible, rsp_bus.last_column);
         end else begin
            want = expected_columns.pop_front();
            if (rsp_bus.column !== want.column || rsp_bus.bar_height !== want.bar ||
                rsp_bus.peak_row !== want.row || rsp_bus.peak_visible !== want.visible ||
                rsp_bus.last_column !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch @%0t exp col %0d bar %0d row %0d vis %0d last %0d | %s",
                           $realtime, want.column, want.bar, want.row, want.visible,
                           want.last, $sformatf("got col %0d bar %0d row %0d vis %0d last %0d",
                           rsp_bus.column, rsp_bus.bar_height, rsp_bus.peak_row,
                           rsp_bus.peak_visible, rsp_bus.last_column));
            end
         end
      end
   end

   // Receiver stalls: segments of always-ready, light, heavy and periodic backpressure
   initial begin
      int mode;
      int span;
      int period;
      int tick;
      rsp_bus.ready <= 1'b0;
      tick = 0;
      forever begin
         mode   = $urandom_range(0, 3);
         span   = $urandom_range(10, 150);
         period = $urandom_range(2, 5);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ((tick % period) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   // Magnitudes spread so bars land across 0..16 for the current divisor
   function automatic logic [MAG_W-1:0] pick_magnitude();
      int unsigned cap;
      cap = ((bar_div == 0) ? 1 : bar_div) * 3 + 200;
      if (cap > 65535) cap = 65535;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return MAG_W'(noise_floor + $urandom_range(0, 2));
         3:       return MAG_W'(noise_floor - 1);
         4:       return MAG_W'($urandom);
         default: return MAG_W'($urandom_range(0, cap));
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Reset config (threshold 100, divisor 50, peaks off): band edges and
   // bins that must be dropped
   task automatic test_bin_range();
      send_bin(5'd0, 16'hFFFF, 1'b0);   // bins 0 and 1 never count
      send_bin(5'd1, 16'hFFFF, 1'b0);
      send_bin(5'd2, 16'd101, 1'b0);    // just above threshold
      send_bin(5'd3, 16'd100, 1'b0);    // at threshold: dropped
      send_bin(5'd4, 16'hFFFF, 1'b0);
      send_bin(5'd16, 16'd5000, 1'b0);  // band edge 16 / 17
      send_bin(5'd17, 16'd777, 1'b0);
      send_bin(5'd31, 16'd1234, 1'b1);  // top bin closes the frame
      wait_for_columns();
   endtask

   // Peaks on: column 1 starts from its reset peak, a bar of 16 clamps the
   // row to 15, then empty frames let the peaks fall
   task automatic test_peak_hold();
      configure(16'd0, 16'd1, 16'd1);
      send_bin(5'd2, 16'd5, 1'b0);
      send_bin(5'd31, 16'hFFFF, 1'b1);
      send_bin(5'd3, 16'd40, 1'b1);
      send_bin(5'd0, 16'd0, 1'b1);       // frame end on an ignored bin
      send_bin(5'd1, 16'hFFFF, 1'b1);
      wait_for_columns();
   endtask

   // Register extremes: divisor 0 and 65535, threshold 65535 and 0
   task automatic test_divisor_extremes();
      configure(16'hFFFF, 16'd0, 16'd1);
      send_bin(5'd31, 16'hFFFF, 1'b0);
      send_bin(5'd10, 16'hFFFF, 1'b1);
      configure(16'hFFFE, 16'hFFFF, 16'd0);
      send_bin(5'd31, 16'hFFFF, 1'b0);
      send_bin(5'd20, 16'hFFFF, 1'b1);
      configure(16'd0, 16'd0, 16'd1);
      send_bin(5'd7, 16'd1, 1'b0);
      send_bin(5'd2, 16'd16, 1'b1);
      wait_for_columns();
   endtask

   // Random frames: mostly well-formed with random content, some saturating
   // frames, some raw noise; config changes and full drains between frames
   task automatic test_random_frames();
      int          kind;
      int          count;
      int          hot_bin;
      logic [15:0] noise;
      logic [15:0] divisor;
      random_requests = 0;
      configure(16'd40, 16'd120, 16'd1);
      while (random_requests < RANDOM_REQS) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // raw noise; frame ends scattered, always closed at the tail
            count = $urandom_range(3, 15);
            for (int i = 0; i < count; i++)
               send_bin(IDX_W'($urandom), MAG_W'($urandom),
                        (i == count - 1) || ($urandom_range(0, 5) == 0));
         end else if (kind == 1) begin
            // one bin repeated, usually hard enough to saturate its band sum
            count   = $urandom_range(33, 45);
            hot_bin = $urandom_range(2, 31);
            for (int i = 0; i < count; i++)
               send_bin(IDX_W'(hot_bin), MAG_W'($urandom_range(60000, 65535)),
                        i == count - 1);
         end else begin
            count = $urandom_range(1, 30);
            for (int i = 0; i < count; i++)
               send_bin(IDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                           : $urandom_range(2, 31)),
                        pick_magnitude(), i == count - 1);
         end
         random_requests += count;
         case ($urandom_range(0, 5))
            0: begin
               case ($urandom_range(0, 5))
                  0:       noise = 16'd0;
                  1:       noise = 16'hFFFF;
                  2:       noise = 16'($urandom);
                  default: noise = 16'($urandom_range(0, 300));
               endcase
               case ($urandom_range(0, 6))
                  0:       divisor = 16'd0;
                  1:       divisor = 16'd1;
                  2:       divisor = 16'hFFFF;
                  3:       divisor = 16'($urandom);
                  default: divisor = 16'($urandom_range(1, 600));
               endcase
               // upper data bits are don't-care for the enable
               configure(noise, divisor,
                         {15'($urandom), 1'($urandom_range(0, 2) != 0)});
            end
            1:       wait_for_columns();   // hold off until all columns are back
            default: ;
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      noise_floor = 100;
      bar_div     = 50;
      peaks_on    = 1'b0;
      for (int c = 0; c < NBANDS; c++) begin
         band_total[c] = 0;
         peak_level[c] = -1;
      end
      peak_level[1] = PEAK_TOP;   // column 1 powers up with a full peak
      errors          = 0;
      requests_sent   = 0;
      frames_sent     = 0;
      columns_checked = 0;
      reg_writes      = 0;
      burst_left      = 0;
      req_up          = 0;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.bin_index <= '0;
      req_bus.magnitude <= '0;
      req_bus.frame_end <= 1'b0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_NOISE_THRESHOLD;
      csr_write_data    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bin_range();
      test_peak_hold();
      test_divisor_extremes();
      test_random_frames();
      wait_for_columns();

      $display("Run covered %0d requests in %0d frames, %0d register writes",
               requests_sent, frames_sent, reg_writes);
      $display("%0d column results checked, %0d mismatches", columns_checked, errors);
      if (errors == 0 && expected_columns.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### spectrum_band_bars_peak_hold.f
design/sbbp_pkg.sv
design/sbbp_req_if.sv
design/sbbp_rsp_if.sv
design/sbbp_ctrl.sv
design/sbbp_datapath.sv
design/spectrum_band_bars_peak_hold.sv
dv/tb.sv
